// ----- hw/rtl/scl_pkg.sv -----
package scl_pkg;

	localparam logic [3:0] TOK_WORD   = 4'd0;
	localparam logic [3:0] TOK_VAR    = 4'd1;
	localparam logic [3:0] TOK_CHAIN  = 4'd2;
	localparam logic [3:0] TOK_PIPE   = 4'd3;
	localparam logic [3:0] TOK_OUT    = 4'd4;
	localparam logic [3:0] TOK_APPEND = 4'd5;
	localparam logic [3:0] TOK_IN     = 4'd6;
	localparam logic [3:0] TOK_EOL    = 4'd7;
	localparam logic [3:0] TOK_IF     = 4'd8;
	localparam logic [3:0] TOK_THEN   = 4'd9;
	localparam logic [3:0] TOK_FI     = 4'd10;
	localparam logic [3:0] TOK_FOR    = 4'd11;
	localparam logic [3:0] TOK_KW_IN  = 4'd12;
	localparam logic [3:0] TOK_DO     = 4'd13;
	localparam logic [3:0] TOK_DONE   = 4'd14;
	localparam logic [3:0] TOK_END    = 4'd15;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;

	localparam int unsigned NUM_KW = 7;

	// raw token as the front end sees it; words are classified downstream
	typedef struct packed {
		logic        is_word;
		logic        ovf;
		logic        dollar;
		logic [31:0] head;
		logic [3:0]  kind;
		logic [15:0] start;
		logic [7:0]  len;
		logic        too_long;
	} scl_tok_t;

	// results of one input item: one or two tokens
	typedef struct packed {
		logic     two;
		scl_tok_t tok1;
		scl_tok_t tok0;
	} scl_entry_t;

	typedef struct packed {
		logic [7:0]  len;
		logic [31:0] head;
		logic [3:0]  kind;
	} scl_kw_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] kind;
	} scl_kw_hit_t;

	localparam scl_kw_t KW_TABLE [NUM_KW] = '{
		'{len: 8'd2, head: 32'h0000_6669, kind: TOK_IF},
		'{len: 8'd4, head: 32'h6E65_6874, kind: TOK_THEN},
		'{len: 8'd2, head: 32'h0000_6966, kind: TOK_FI},
		'{len: 8'd3, head: 32'h0072_6F66, kind: TOK_FOR},
		'{len: 8'd2, head: 32'h0000_6E69, kind: TOK_KW_IN},
		'{len: 8'd2, head: 32'h0000_6F64, kind: TOK_DO},
		'{len: 8'd4, head: 32'h656E_6F64, kind: TOK_DONE}
	};

	function automatic scl_kw_hit_t kw_match(logic [7:0] len, logic [31:0] head);
		scl_kw_hit_t res;
		res.hit  = 1'b0;
		res.kind = TOK_WORD;
		for (int i = 0; i < NUM_KW; i++) begin
			if (KW_TABLE[i].len == len && KW_TABLE[i].head == head) begin
				res.hit  = 1'b1;
				res.kind = KW_TABLE[i].kind;
			end
		end
		return res;
	endfunction

endpackage

// ----- hw/rtl/scl_front.sv -----
module scl_front #(
	parameter int unsigned MAX_TOKEN = 255,
	parameter int unsigned MAX_LINE  = 65535
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_char,
	input  logic               full,
	output logic               push,
	output scl_pkg::scl_entry_t push_data
);

	localparam int unsigned LEN_CAP_I = (MAX_TOKEN < 255) ? MAX_TOKEN : 255;
	localparam int unsigned OFF_CAP_I = (MAX_LINE < 65535) ? MAX_LINE : 65535;
	localparam logic [7:0]  LEN_CAP   = LEN_CAP_I[7:0];
	localparam logic [15:0] OFF_CAP   = OFF_CAP_I[15:0];

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_FF     = 8'hFF;

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_QUOTE,
		MODE_GT
	} mode_t;

	mode_t       mode_q, mode_nxt;
	logic [7:0]  plen_q, plen_nxt;
	logic [15:0] pstart_q, pstart_nxt;
	logic [31:0] head_q, head_nxt;
	logic        dollar_q, dollar_nxt;
	logic        ovf_q, ovf_nxt;
	logic [15:0] line_pos_q, line_pos_nxt;

	logic        accept;
	logic        push_c;
	logic        is_end;
	logic        has_word;
	logic        lead_valid;
	logic        sep_hit;
	logic [3:0]  sep_kind;
	logic [7:0]  base_len, add_len;
	logic [15:0] base_start;
	logic [31:0] base_head, add_head;
	logic        base_dollar, add_dollar;
	logic        base_ovf, add_ovf;
	scl_pkg::scl_tok_t word_tok, out_tok, end_tok, sep_tok, app_tok, lead_tok;
	scl_pkg::scl_entry_t entry;

	function automatic scl_pkg::scl_tok_t simple_tok(logic [3:0] kind, logic [15:0] start,
			logic [7:0] len);
		scl_pkg::scl_tok_t t;
		t.is_word  = 1'b0;
		t.ovf      = 1'b0;
		t.dollar   = 1'b0;
		t.head     = 32'd0;
		t.kind     = kind;
		t.start    = start;
		t.len      = len;
		t.too_long = (start == OFF_CAP);
		return t;
	endfunction

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && push_c;
	assign push_data = entry;

	always_comb begin
		is_end   = (in_char == CH_NUL) || (in_char == CH_FF);
		has_word = (plen_q != 8'd0);

		word_tok.is_word  = 1'b1;
		word_tok.ovf      = ovf_q;
		word_tok.dollar   = dollar_q;
		word_tok.head     = head_q;
		word_tok.kind     = scl_pkg::TOK_WORD;
		word_tok.start    = pstart_q;
		word_tok.len      = plen_q;
		word_tok.too_long = ovf_q || (pstart_q == OFF_CAP);

		out_tok = simple_tok(scl_pkg::TOK_OUT, pstart_q, 8'd1);
		app_tok = simple_tok(scl_pkg::TOK_APPEND, pstart_q, 8'd2);
		end_tok = simple_tok(scl_pkg::TOK_END, line_pos_q, 8'd0);

		sep_hit = in_char inside {CH_SEMI, CH_PIPE, CH_LT, CH_NL};
		case (in_char)
			CH_SEMI: sep_kind = scl_pkg::TOK_CHAIN;
			CH_PIPE: sep_kind = scl_pkg::TOK_PIPE;
			CH_LT:   sep_kind = scl_pkg::TOK_IN;
			default: sep_kind = scl_pkg::TOK_EOL;
		endcase
		sep_tok = simple_tok(sep_kind, line_pos_q, 8'd1);

		lead_valid = (mode_q == MODE_GT) || has_word;
		lead_tok   = (mode_q == MODE_GT) ? out_tok : word_tok;

		// append one byte to the pending word
		base_len    = plen_q;
		base_start  = has_word ? pstart_q : line_pos_q;
		base_head   = has_word ? head_q : 32'd0;
		base_dollar = has_word && dollar_q;
		base_ovf    = has_word && ovf_q;
		add_len     = base_len;
		add_head    = base_head;
		add_ovf     = base_ovf;
		if (base_len < LEN_CAP) begin
			if (base_len < 8'd4) begin
				add_head = base_head | ({24'd0, in_char} << {base_len[1:0], 3'b000});
			end
			add_len = base_len + 8'd1;
		end else begin
			add_ovf = 1'b1;
		end
		add_dollar = base_dollar || (in_char == CH_DOLLAR);

		mode_nxt     = mode_q;
		plen_nxt     = plen_q;
		pstart_nxt   = pstart_q;
		head_nxt     = head_q;
		dollar_nxt   = dollar_q;
		ovf_nxt      = ovf_q;
		line_pos_nxt = (line_pos_q < OFF_CAP) ? line_pos_q + 16'd1 : line_pos_q;
		push_c       = 1'b0;
		entry.two    = 1'b0;
		entry.tok0   = lead_tok;
		entry.tok1   = end_tok;

		if (is_end) begin
			push_c       = 1'b1;
			entry.two    = lead_valid;
			entry.tok0   = lead_valid ? lead_tok : end_tok;
			mode_nxt     = MODE_NORMAL;
			plen_nxt     = 8'd0;
			pstart_nxt   = 16'd0;
			head_nxt     = 32'd0;
			dollar_nxt   = 1'b0;
			ovf_nxt      = 1'b0;
			line_pos_nxt = 16'd0;
		end else begin
			case (mode_q)
				MODE_QUOTE: begin
					plen_nxt   = add_len;
					pstart_nxt = base_start;
					head_nxt   = add_head;
					dollar_nxt = add_dollar;
					ovf_nxt    = add_ovf;
					if (in_char == CH_QUOTE) begin
						mode_nxt = MODE_NORMAL;
					end
				end
				default: begin
					mode_nxt = MODE_NORMAL;
					if (mode_q == MODE_GT && in_char == CH_GT) begin
						push_c     = 1'b1;
						entry.tok0 = app_tok;
					end else if (in_char == CH_SPACE || in_char == CH_TAB) begin
						push_c     = lead_valid;
						plen_nxt   = 8'd0;
						head_nxt   = 32'd0;
						dollar_nxt = 1'b0;
						ovf_nxt    = 1'b0;
					end else if (sep_hit) begin
						push_c     = 1'b1;
						entry.two  = lead_valid;
						entry.tok0 = lead_valid ? lead_tok : sep_tok;
						entry.tok1 = sep_tok;
						plen_nxt   = 8'd0;
						head_nxt   = 32'd0;
						dollar_nxt = 1'b0;
						ovf_nxt    = 1'b0;
					end else if (in_char == CH_GT) begin
						push_c     = lead_valid;
						plen_nxt   = 8'd0;
						head_nxt   = 32'd0;
						dollar_nxt = 1'b0;
						ovf_nxt    = 1'b0;
						pstart_nxt = line_pos_q;
						mode_nxt   = MODE_GT;
					end else begin
						push_c     = (mode_q == MODE_GT);
						entry.tok0 = out_tok;
						plen_nxt   = add_len;
						pstart_nxt = base_start;
						head_nxt   = add_head;
						dollar_nxt = add_dollar;
						ovf_nxt    = add_ovf;
						if (in_char == CH_QUOTE) begin
							mode_nxt = MODE_QUOTE;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_NORMAL;
			plen_q     <= 8'd0;
			pstart_q   <= 16'd0;
			head_q     <= 32'd0;
			dollar_q   <= 1'b0;
			ovf_q      <= 1'b0;
			line_pos_q <= 16'd0;
		end else if (accept) begin
			mode_q     <= mode_nxt;
			plen_q     <= plen_nxt;
			pstart_q   <= pstart_nxt;
			head_q     <= head_nxt;
			dollar_q   <= dollar_nxt;
			ovf_q      <= ovf_nxt;
			line_pos_q <= line_pos_nxt;
		end
	end

	// a pending word never coexists with a waiting >
	a_gt_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_GT) |-> (plen_q == 8'd0))
		else $error("pending word while > is waiting");

endmodule

// ----- hw/rtl/scl_queue.sv -----
module scl_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  scl_pkg::scl_entry_t push_data,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output scl_pkg::scl_entry_t head_data
);

	localparam logic [scl_pkg::QCNT_W-1:0] DEPTH_C = scl_pkg::QCNT_W'(scl_pkg::QUEUE_DEPTH);

	scl_pkg::scl_entry_t mem_q [scl_pkg::QUEUE_DEPTH];
	logic [scl_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [scl_pkg::QCNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign full       = (cnt_q == DEPTH_C);
	assign head_valid = (cnt_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + scl_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + scl_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + scl_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - scl_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("queue count out of range");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

// ----- hw/rtl/scl_back.sv -----
module scl_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  scl_pkg::scl_entry_t q_entry,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,
	output logic                m_tlast
);

	logic              load;
	logic              sel_q;
	logic              final_tok;
	logic              m_tvalid_q;
	logic [31:0]       m_tdata_q;
	logic              m_tlast_q;
	logic [3:0]        tok_type;
	scl_pkg::scl_tok_t cur;
	scl_pkg::scl_kw_hit_t kw;

	assign load      = q_valid && (!m_tvalid_q || m_tready);
	assign cur       = sel_q ? q_entry.tok1 : q_entry.tok0;
	assign final_tok = sel_q || !q_entry.two;
	assign q_pop     = load && final_tok;

	always_comb begin
		kw = scl_pkg::kw_match(cur.len, cur.head);
		if (!cur.is_word) begin
			tok_type = cur.kind;
		end else if (kw.hit && !cur.ovf) begin
			tok_type = kw.kind;
		end else if (cur.dollar) begin
			tok_type = scl_pkg::TOK_VAR;
		end else begin
			tok_type = scl_pkg::TOK_WORD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			sel_q      <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
			sel_q      <= !final_tok;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= {3'b000, cur.too_long, cur.len, cur.start, tok_type};
			m_tlast_q <= final_tok;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// second token pending means the head entry holds two tokens
	a_sel_two: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> (q_valid && q_entry.two))
		else $error("second token selected without a two-token entry");

endmodule

// ----- hw/rtl/shell_command_lexer.sv -----
// Shell command lexer: one command-line byte enters per cycle on the s_ side
// while the queue is not full, and tokens leave on the m_ side as type, start
// offset, length and an overflow flag, with tlast on the final token caused by
// a byte. The lexer front end keeps the word state and classifies bytes; a
// four-item queue feeds the token formatter, which matches keywords and drives
// a registered output, one token per cycle while m_tready is high. A byte that
// yields two tokens (a word or a waiting > before a separator or end byte)
// sends both in turn; bytes that yield none send nothing. A 0x00 or 0xFF byte
// closes the line with an end token.
module shell_command_lexer #(
	parameter int unsigned MAX_TOKEN = 255,
	parameter int unsigned MAX_LINE  = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [3:0] token_type, [19:4] token_start,
	                               // [27:20] token_length, [28] too_long
	output logic        m_tlast
);

	logic                push, full, pop, head_valid;
	scl_pkg::scl_entry_t push_data, head_data;

	scl_front #(
		.MAX_TOKEN(MAX_TOKEN),
		.MAX_LINE (MAX_LINE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_char  (s_tdata),
		.full     (full),
		.push     (push),
		.push_data(push_data)
	);

	scl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_data (head_data)
	);

	scl_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (head_valid),
		.q_entry (head_data),
		.q_pop   (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule
